// ===== design/crtess_pkg.sv =====
// ============================================================================
// crtess_pkg
// Shared types, widths and constants of the Catmull-Rom curve tessellator.
// ============================================================================
package crtess_pkg;

    localparam int COORD_W    = 16;
    localparam int T_W        = 16;
    localparam int W_W        = 20;
    localparam int MA_W       = W_W;
    localparam int MB_W       = ((COORD_W > T_W) ? COORD_W : T_W) + 1;
    localparam int PROD_W     = MA_W + MB_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int FRAC_SHIFT = 17;
    localparam int SHR_W      = ACC_W - FRAC_SHIFT;
    localparam int SUM_W      = SHR_W + 1;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_W      = (COORD_W > T_W) ? COORD_W : T_W;
    localparam int K_W        = 4;

    localparam logic [K_W-1:0] K_X_FIRST = K_W'(1);
    localparam logic [K_W-1:0] K_Y_FIRST = K_W'(5);
    localparam logic [K_W-1:0] K_LAST    = K_W'(8);

    localparam logic [T_W-1:0] MIN_STEP   = T_W'(2048);
    localparam logic [T_W-1:0] T_STEP_RST = T_W'(2621);

    localparam logic signed [W_W-1:0] W_TWO = W_W'(131072);

    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_MAX  = 2'd3;

    localparam logic OPC_POINT = 1'b0;
    localparam logic OPC_END   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_T_STEP    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y  = CFG_IDX_W'(3);

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef struct packed {
        logic   opcode;
        t_coord point_x;
        t_coord point_y;
    } t_in_item;

    typedef struct packed {
        t_coord curve_x;
        t_coord curve_y;
        logic   run_last;
    } t_out_item;

    typedef struct packed {
        logic           loop_mode;
        logic [T_W-1:0] t_step;
        t_coord         offset_x;
        t_coord         offset_y;
    } t_cfg;

    typedef struct packed {
        logic signed [MA_W-1:0] op_a;
        logic signed [MB_W-1:0] op_b;
        logic                   acc_en;
        logic                   acc_load;
    } t_mac_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_CUBE,
        ST_WGT,
        ST_MAC,
        ST_OUT
    } t_state;

    function automatic t_coord sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            sat_coord = hi[COORD_W-1:0];
        end else if (v < lo) begin
            sat_coord = lo[COORD_W-1:0];
        end else begin
            sat_coord = v[COORD_W-1:0];
        end
    endfunction

endpackage

// ===== design/crtess_mac.sv =====
// ============================================================================
// crtess_mac
// Shared signed multiplier with registered product and accumulator.
// ============================================================================
module crtess_mac (
    input  logic                                      i_clk,
    input  crtess_pkg::t_mac_ctl                      i_ctl,
    output logic signed [crtess_pkg::PROD_W-1:0]      o_prod,
    output logic signed [crtess_pkg::ACC_W-1:0]       o_acc
);

    logic signed [crtess_pkg::PROD_W-1:0] r_prod;
    logic signed [crtess_pkg::ACC_W-1:0]  r_acc;
    logic signed [crtess_pkg::MA_W-1:0]   w_a;
    logic signed [crtess_pkg::MB_W-1:0]   w_b;
    logic signed [crtess_pkg::ACC_W-1:0]  w_prod_ext;

    assign w_a        = i_ctl.op_a;
    assign w_b        = i_ctl.op_b;
    assign w_prod_ext = crtess_pkg::ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
        if (i_ctl.acc_en) begin
            r_acc <= i_ctl.acc_load ? w_prod_ext : (r_acc + w_prod_ext);
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

// ===== design/crtess_ctrl.sv =====
// ============================================================================
// crtess_ctrl
// Sequencer, curve state, weight build and result formatting.
// ============================================================================
module crtess_ctrl (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  crtess_pkg::t_cfg                      i_cfg,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  crtess_pkg::t_in_item                  i_in_item,
    input  logic                                  i_out_free,
    output logic                                  o_emit,
    output crtess_pkg::t_out_item                 o_emit_item,
    output crtess_pkg::t_mac_ctl                  o_mac_ctl,
    input  logic signed [crtess_pkg::PROD_W-1:0]  i_prod,
    input  logic signed [crtess_pkg::ACC_W-1:0]   i_acc
);

    crtess_pkg::t_state r_state, n_state;
    crtess_pkg::t_point r_rec [3];
    crtess_pkg::t_point n_rec [3];
    crtess_pkg::t_point r_first, n_first;
    crtess_pkg::t_point r_p4, n_p4;
    logic [1:0]         r_seen, n_seen;
    logic               r_two, n_two;
    logic               r_shift, n_shift;
    logic               r_clear, n_clear;

    logic [crtess_pkg::T_W-1:0]           r_t, n_t;
    logic [crtess_pkg::T_W-1:0]           r_t2, n_t2;
    logic signed [crtess_pkg::W_W-1:0]    r_w [4];
    logic signed [crtess_pkg::W_W-1:0]    n_w [4];
    logic [crtess_pkg::K_W-1:0]           r_k, n_k;
    logic signed [crtess_pkg::ACC_W-1:0]  r_sumx, n_sumx;

    logic [crtess_pkg::T_W-1:0]           w_step;
    logic [crtess_pkg::T_W:0]             w_t_next;
    logic                                 w_done;
    logic [crtess_pkg::T_W-1:0]           w_t3;
    logic signed [crtess_pkg::W_W-1:0]    w_et, w_e2, w_e3;
    crtess_pkg::t_point                   w_win [4];
    crtess_pkg::t_point                   w_sel;
    crtess_pkg::t_point                   w_in_pt;
    crtess_pkg::t_coord                   w_coord;
    crtess_pkg::t_coord                   w_off_x, w_off_y;
    logic signed [crtess_pkg::SHR_W-1:0]  w_shr_x, w_shr_y;
    logic signed [crtess_pkg::SUM_W-1:0]  w_sum_x, w_sum_y;

    assign w_step   = (i_cfg.t_step < crtess_pkg::MIN_STEP) ? crtess_pkg::MIN_STEP
                                                             : i_cfg.t_step;
    assign w_t_next = {1'b0, r_t} + {1'b0, w_step};
    assign w_done   = w_t_next[crtess_pkg::T_W];
    assign w_t3     = i_prod[2*crtess_pkg::T_W-1:crtess_pkg::T_W];

    assign w_et = crtess_pkg::W_W'(r_t);
    assign w_e2 = crtess_pkg::W_W'(r_t2);
    assign w_e3 = crtess_pkg::W_W'(w_t3);

    assign w_win[0] = r_rec[0];
    assign w_win[1] = r_rec[1];
    assign w_win[2] = r_rec[2];
    assign w_win[3] = r_p4;
    assign w_sel    = w_win[r_k[1:0]];
    assign w_coord  = r_k[2] ? w_sel.y : w_sel.x;

    assign w_in_pt.x = i_in_item.point_x;
    assign w_in_pt.y = i_in_item.point_y;

    // floor of the weighted sum over 2^17, then offset and saturate
    assign w_off_x = i_cfg.offset_x;
    assign w_off_y = i_cfg.offset_y;
    assign w_shr_x = r_sumx[crtess_pkg::ACC_W-1:crtess_pkg::FRAC_SHIFT];
    assign w_shr_y = i_acc[crtess_pkg::ACC_W-1:crtess_pkg::FRAC_SHIFT];
    assign w_sum_x = crtess_pkg::SUM_W'(w_shr_x) + crtess_pkg::SUM_W'(w_off_x);
    assign w_sum_y = crtess_pkg::SUM_W'(w_shr_y) + crtess_pkg::SUM_W'(w_off_y);

    assign o_emit_item.curve_x  = crtess_pkg::sat_coord(w_sum_x);
    assign o_emit_item.curve_y  = crtess_pkg::sat_coord(w_sum_y);
    assign o_emit_item.run_last = w_done && !r_two;

    assign o_in_stall = (r_state != crtess_pkg::ST_IDLE);

    always_comb begin
        n_state  = r_state;
        n_rec    = r_rec;
        n_first  = r_first;
        n_p4     = r_p4;
        n_seen   = r_seen;
        n_two    = r_two;
        n_shift  = r_shift;
        n_clear  = r_clear;
        n_t      = r_t;
        n_t2     = r_t2;
        n_w      = r_w;
        n_k      = r_k;
        n_sumx   = r_sumx;
        o_emit   = 1'b0;
        o_mac_ctl.op_a     = '0;
        o_mac_ctl.op_b     = '0;
        o_mac_ctl.acc_en   = 1'b0;
        o_mac_ctl.acc_load = 1'b0;

        unique case (r_state)
            crtess_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_t = '0;
                    if (i_in_item.opcode == crtess_pkg::OPC_POINT) begin
                        if (r_seen != crtess_pkg::SEEN_MAX) begin
                            n_seen = r_seen + 2'd1;
                        end
                        if (r_seen == crtess_pkg::SEEN_NONE) begin
                            n_first  = w_in_pt;
                            n_rec[0] = r_rec[2];
                            n_rec[1] = w_in_pt;
                            n_rec[2] = w_in_pt;
                        end else if (r_seen == crtess_pkg::SEEN_ONE) begin
                            n_rec[0] = r_rec[1];
                            n_rec[1] = r_rec[2];
                            n_rec[2] = w_in_pt;
                        end else begin
                            n_p4    = w_in_pt;
                            n_two   = 1'b0;
                            n_shift = 1'b1;
                            n_clear = 1'b0;
                            n_state = crtess_pkg::ST_SQ;
                        end
                    end else begin
                        n_two   = 1'b0;
                        n_shift = 1'b0;
                        n_clear = 1'b1;
                        if (i_cfg.loop_mode && r_seen != crtess_pkg::SEEN_NONE) begin
                            n_p4    = r_first;
                            n_state = crtess_pkg::ST_SQ;
                            if (r_seen == crtess_pkg::SEEN_ONE) begin
                                n_rec[0] = r_rec[1];
                                n_rec[1] = r_rec[2];
                                n_rec[2] = r_first;
                            end else begin
                                n_two = 1'b1;
                            end
                        end else if (!i_cfg.loop_mode && r_seen != crtess_pkg::SEEN_NONE
                                     && r_seen != crtess_pkg::SEEN_ONE) begin
                            n_p4    = r_rec[2];
                            n_state = crtess_pkg::ST_SQ;
                        end else begin
                            n_rec[0] = '0;
                            n_rec[1] = '0;
                            n_rec[2] = '0;
                            n_first  = '0;
                            n_seen   = crtess_pkg::SEEN_NONE;
                        end
                    end
                end
            end
            crtess_pkg::ST_SQ: begin
                o_mac_ctl.op_a = crtess_pkg::MA_W'(r_t);
                o_mac_ctl.op_b = crtess_pkg::MB_W'(r_t);
                n_state = crtess_pkg::ST_CUBE;
            end
            crtess_pkg::ST_CUBE: begin
                n_t2 = i_prod[2*crtess_pkg::T_W-1:crtess_pkg::T_W];
                o_mac_ctl.op_a = crtess_pkg::MA_W'(n_t2);
                o_mac_ctl.op_b = crtess_pkg::MB_W'(r_t);
                n_state = crtess_pkg::ST_WGT;
            end
            crtess_pkg::ST_WGT: begin
                n_w[0] = -w_e3 + (w_e2 <<< 1) - w_et;
                n_w[1] = (w_e3 <<< 1) + w_e3 - (w_e2 <<< 2) - w_e2 + crtess_pkg::W_TWO;
                n_w[2] = -((w_e3 <<< 1) + w_e3) + (w_e2 <<< 2) + w_et;
                n_w[3] = w_e3 - w_e2;
                n_k     = '0;
                n_state = crtess_pkg::ST_MAC;
            end
            crtess_pkg::ST_MAC: begin
                // x products on steps 0..3, y on 4..7, each accumulated on the next step
                if (r_k != crtess_pkg::K_LAST) begin
                    o_mac_ctl.op_a = r_w[r_k[1:0]];
                    o_mac_ctl.op_b = crtess_pkg::MB_W'(w_coord);
                end
                o_mac_ctl.acc_en   = (r_k != '0);
                o_mac_ctl.acc_load = (r_k == crtess_pkg::K_X_FIRST) ||
                                     (r_k == crtess_pkg::K_Y_FIRST);
                if (r_k == crtess_pkg::K_Y_FIRST) begin
                    n_sumx = i_acc;
                end
                if (r_k == crtess_pkg::K_LAST) begin
                    n_state = crtess_pkg::ST_OUT;
                end else begin
                    n_k = r_k + crtess_pkg::K_W'(1);
                end
            end
            crtess_pkg::ST_OUT: begin
                if (i_out_free) begin
                    o_emit = 1'b1;
                    if (!w_done) begin
                        n_t     = w_t_next[crtess_pkg::T_W-1:0];
                        n_state = crtess_pkg::ST_SQ;
                    end else if (r_two) begin
                        n_rec[0] = r_rec[1];
                        n_rec[1] = r_rec[2];
                        n_rec[2] = r_p4;
                        n_two    = 1'b0;
                        n_t      = '0;
                        n_state  = crtess_pkg::ST_SQ;
                    end else begin
                        if (r_shift) begin
                            n_rec[0] = r_rec[1];
                            n_rec[1] = r_rec[2];
                            n_rec[2] = r_p4;
                        end
                        if (r_clear) begin
                            n_rec[0] = '0;
                            n_rec[1] = '0;
                            n_rec[2] = '0;
                            n_first  = '0;
                            n_seen   = crtess_pkg::SEEN_NONE;
                        end
                        n_state = crtess_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = crtess_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crtess_pkg::ST_IDLE;
            r_rec[0] <= '0;
            r_rec[1] <= '0;
            r_rec[2] <= '0;
            r_first <= '0;
            r_seen  <= crtess_pkg::SEEN_NONE;
            r_two   <= 1'b0;
            r_shift <= 1'b0;
            r_clear <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rec   <= n_rec;
            r_first <= n_first;
            r_seen  <= n_seen;
            r_two   <= n_two;
            r_shift <= n_shift;
            r_clear <= n_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p4   <= n_p4;
        r_t    <= n_t;
        r_t2   <= n_t2;
        r_w    <= n_w;
        r_k    <= n_k;
        r_sumx <= n_sumx;
    end

endmodule

// ===== design/catmull_rom_curve_tessellator_top.sv =====
// ============================================================================
// catmull_rom_curve_tessellator_top
// Uniform Catmull-Rom tessellator: control points in, curve points out.
// ============================================================================
//  channel | direction | handshake           | payload
//  in      | input     | i_in_valid/o_in_stall | t_in_item (opcode, point)
//  out     | output    | o_out_valid/i_out_stall | t_out_item (curve point)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  Each curve point is computed on the single shared multiplier in these steps:
//  t^2, t^3, weights, eight products, format. A window gives ceil(65536/step)
//  points, an item zero to two windows (26 points per window at reset step).
//  The input is stalled from acceptance until the last point is registered.
//  A stalled output holds the sequencer in its format step.
//  Reset is synchronous, active low; no clearing pass.
// ============================================================================
module catmull_rom_curve_tessellator_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  crtess_pkg::t_in_item                  i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output crtess_pkg::t_out_item                 o_out_item,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [crtess_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [crtess_pkg::CFG_W-1:0]          i_cfg_data
);

    crtess_pkg::t_cfg                     r_cfg;
    logic                                 r_out_valid;
    crtess_pkg::t_out_item                r_out_item;
    logic                                 w_out_free;
    logic                                 w_emit;
    crtess_pkg::t_out_item                w_emit_item;
    crtess_pkg::t_mac_ctl                 w_mac_ctl;
    logic signed [crtess_pkg::PROD_W-1:0] w_prod;
    logic signed [crtess_pkg::ACC_W-1:0]  w_acc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loop_mode <= 1'b0;
            r_cfg.t_step    <= crtess_pkg::T_STEP_RST;
            r_cfg.offset_x  <= '0;
            r_cfg.offset_y  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                crtess_pkg::REG_LOOP_MODE: r_cfg.loop_mode <= i_cfg_data[0];
                crtess_pkg::REG_T_STEP:    r_cfg.t_step <= i_cfg_data[crtess_pkg::T_W-1:0];
                crtess_pkg::REG_OFFSET_X:  r_cfg.offset_x <= i_cfg_data[crtess_pkg::COORD_W-1:0];
                crtess_pkg::REG_OFFSET_Y:  r_cfg.offset_y <= i_cfg_data[crtess_pkg::COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // output item register
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_item <= w_emit_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    crtess_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_out_free  (w_out_free),
        .o_emit      (w_emit),
        .o_emit_item (w_emit_item),
        .o_mac_ctl   (w_mac_ctl),
        .i_prod      (w_prod),
        .i_acc       (w_acc)
    );

    crtess_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_mac_ctl),
        .o_prod (w_prod),
        .o_acc  (w_acc)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the Catmull-Rom curve tessellator. Control and end
// items go in from a queue through a clocked driver; a local predictor works
// out the curve points of every accepted item, and a clocked monitor checks
// each output item against them in order. Directed curves and register
// extremes come first, then random curves over several register settings,
// with random idling on both channels and one long output hold-off.
// ============================================================================
module tb_top;
    import crtess_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int LONG_HOLD   = 2000;
    localparam int SETTLE_CYC  = 100;
    localparam int MAX_REPORTS = 100;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_item;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    catmull_rom_curve_tessellator_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // pending input items and expected curve points
    t_in_item  pend_items[$];
    t_out_item curve_pts_q[$];

    // predictor copy of registers and curve state
    logic           cfg_loop;
    logic [T_W-1:0] cfg_step;
    t_coord         cfg_offx;
    t_coord         cfg_offy;
    t_point         crv_recent[3];
    t_point         crv_first;
    logic [1:0]     crv_seen;
    t_out_item      held_pt;
    logic           has_held;

    int  send_idle_pct;
    int  recv_idle_pct;
    int  n_accepted;
    int  n_checked;
    int  n_err;
    int  n_settings;
    int  cycle_cnt;
    int  hold_cnt;
    logic hold_want;
    logic hold_done;
    logic in_took;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_coord clip(input longint v);
        longint hi;
        hi = (longint'(1) << (COORD_W - 1)) - 1;
        if (v > hi) return t_coord'(hi);
        if (v < -hi - 1) return t_coord'(-hi - 1);
        return t_coord'(v);
    endfunction

    function automatic longint catmull_eval(input longint t, input longint a,
                                            input longint b, input longint c,
                                            input longint d);
        longint t2, t3, w1, w2, w3, w4;
        t2 = (t * t) >>> T_W;
        t3 = (t2 * t) >>> T_W;
        w1 = -t3 + 2 * t2 - t;
        w2 = 3 * t3 - 5 * t2 + longint'(W_TWO);
        w3 = -3 * t3 + 4 * t2 + t;
        w4 = t3 - t2;
        // arithmetic shift gives the floor of the halving and t scaling
        return (w1 * a + w2 * b + w3 * c + w4 * d) >>> FRAC_SHIFT;
    endfunction

    function automatic void emit_segment(input t_point p4);
        longint    step;
        longint    t;
        t_out_item r;
        step = (cfg_step < MIN_STEP) ? longint'(MIN_STEP) : longint'(cfg_step);
        for (t = 0; t < (longint'(1) << T_W); t += step) begin
            r.curve_x = clip(catmull_eval(t, crv_recent[0].x, crv_recent[1].x,
                                          crv_recent[2].x, p4.x) + cfg_offx);
            r.curve_y = clip(catmull_eval(t, crv_recent[0].y, crv_recent[1].y,
                                          crv_recent[2].y, p4.y) + cfg_offy);
            r.run_last = 1'b0;
            if (has_held) curve_pts_q.insert(curve_pts_q.size(), held_pt);
            held_pt  = r;
            has_held = 1'b1;
        end
    endfunction

    function automatic void shift_in(input t_point p);
        crv_recent[0] = crv_recent[1];
        crv_recent[1] = crv_recent[2];
        crv_recent[2] = p;
    endfunction

    function automatic void tessellate_item(input t_in_item it);
        t_point p;
        has_held = 1'b0;
        if (it.opcode == OPC_POINT) begin
            p.x = it.point_x;
            p.y = it.point_y;
            if (crv_seen == SEEN_NONE) begin
                crv_first = p;
                shift_in(p);
                shift_in(p);
            end else begin
                if (crv_seen > SEEN_ONE) emit_segment(p);
                shift_in(p);
            end
            if (crv_seen != SEEN_MAX) crv_seen = crv_seen + 2'd1;
        end else begin
            if (cfg_loop) begin
                if (crv_seen != SEEN_NONE) begin
                    if (crv_seen > SEEN_ONE) emit_segment(crv_first);
                    shift_in(crv_first);
                    emit_segment(crv_first);
                end
            end else if (crv_seen > SEEN_ONE) begin
                emit_segment(crv_recent[2]);
            end
            crv_recent[0] = '0;
            crv_recent[1] = '0;
            crv_recent[2] = '0;
            crv_first     = '0;
            crv_seen      = SEEN_NONE;
        end
        if (has_held) begin
            held_pt.run_last = 1'b1;
            curve_pts_q.insert(curve_pts_q.size(), held_pt);
            has_held = 1'b0;
        end
    endfunction

    // input driver
    always @(posedge i_clk) begin
        in_took <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            tessellate_item(i_in_item);
            n_accepted++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_in_valid || in_took) begin
            if (pend_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_item  <= pend_items.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall, with one long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_want && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_cnt    <= hold_cnt + 1;
            if (hold_cnt == LONG_HOLD - 1) hold_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // output monitor
    always @(posedge i_clk) begin : mon
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (curve_pts_q.size() == 0) begin
                n_err++;
                if (n_err <= MAX_REPORTS)
                    $display("%0t unexpected item x=%0d y=%0d last=%0b", $time,
                             o_out_item.curve_x, o_out_item.curve_y, o_out_item.run_last);
            end else begin
                want = curve_pts_q.pop_front();
                n_checked++;
                if (o_out_item.curve_x !== want.curve_x ||
                    o_out_item.curve_y !== want.curve_y ||
                    o_out_item.run_last !== want.run_last) begin
                    n_err++;
                    if (n_err <= MAX_REPORTS)
                        $display("%0t mismatch exp x=%0d y=%0d last=%0b got x=%0d y=%0d last=%0b",
                                 $time, want.curve_x, want.curve_y, want.run_last,
                                 o_out_item.curve_x, o_out_item.curve_y,
                                 o_out_item.run_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout with %0d curve points outstanding", curve_pts_q.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 7))
            0: return t_coord'(32767);
            1: return t_coord'(-32768);
            2: return t_coord'(int'($urandom_range(0, 255)) - 128);
            default: return t_coord'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void add_point(input t_coord x, input t_coord y);
        t_in_item it;
        it.opcode  = OPC_POINT;
        it.point_x = x;
        it.point_y = y;
        pend_items.insert(pend_items.size(), it);
    endfunction

    function automatic void add_end();
        t_in_item it;
        it.opcode  = OPC_END;
        it.point_x = rand_coord();
        it.point_y = rand_coord();
        pend_items.insert(pend_items.size(), it);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_LOOP_MODE: cfg_loop = val[0];
            REG_T_STEP:    cfg_step = val[T_W-1:0];
            REG_OFFSET_X:  cfg_offx = t_coord'(val);
            REG_OFFSET_Y:  cfg_offy = t_coord'(val);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic lp, input logic [T_W-1:0] st,
                                 input t_coord ox, input t_coord oy);
        write_reg(REG_LOOP_MODE, CFG_W'(lp));
        write_reg(REG_T_STEP, CFG_W'(st));
        write_reg(REG_OFFSET_X, CFG_W'(ox));
        write_reg(REG_OFFSET_Y, CFG_W'(oy));
        n_settings++;
    endtask

    task automatic settle();
        while (pend_items.size() != 0 || i_in_valid || curve_pts_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic add_random_items(input int count);
        int added;
        int kind;
        int len;
        added = 0;
        while (added < count) begin
            kind = $urandom_range(0, 9);
            len  = (kind == 0) ? 0 : (kind == 1) ? 1 : $urandom_range(2, 6);
            repeat (len) add_point(rand_coord(), rand_coord());
            // some curves run on into the next one
            if (kind != 9) add_end();
            added += len + 1;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        i_out_stall   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        in_took       = 1'b0;
        hold_want     = 1'b0;
        hold_done     = 1'b0;
        hold_cnt      = 0;
        cycle_cnt     = 0;
        n_accepted    = 0;
        n_checked     = 0;
        n_err         = 0;
        n_settings    = 1;
        cfg_loop      = 1'b0;
        cfg_step      = T_STEP_RST;
        cfg_offx      = '0;
        cfg_offy      = '0;
        crv_recent[0] = '0;
        crv_recent[1] = '0;
        crv_recent[2] = '0;
        crv_first     = '0;
        crv_seen      = SEEN_NONE;
        has_held      = 1'b0;
        send_idle_pct = 35;
        recv_idle_pct = 63;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, empty end, open single point, extremes
        add_end();
        add_point(t_coord'(0), t_coord'(0));
        add_end();
        add_point(t_coord'(32767), t_coord'(-32768));
        add_point(t_coord'(-32768), t_coord'(32767));
        add_point(t_coord'(0), t_coord'(-1));
        add_point(t_coord'(-1), t_coord'(0));
        add_end();
        settle();

        // directed: loop mode, largest step, offset extremes
        apply_setting(1'b1, T_W'(65535), t_coord'(32767), t_coord'(-32768));
        add_point(t_coord'(100), t_coord'(-100));
        add_end();
        add_point(t_coord'(32767), t_coord'(32767));
        add_point(t_coord'(-32768), t_coord'(-32768));
        add_end();
        add_end();
        add_point(t_coord'(-1), t_coord'(-1));
        add_point(t_coord'(5), t_coord'(7));
        add_point(t_coord'(32767), t_coord'(0));
        add_end();
        settle();

        // directed: zero step falls back to the minimum step
        apply_setting(1'b0, T_W'(0), t_coord'(0), t_coord'(0));
        add_point(t_coord'(-32768), t_coord'(32767));
        add_point(t_coord'(32767), t_coord'(-32768));
        add_point(t_coord'(16), t_coord'(-16));
        add_end();
        settle();

        // random curves
        apply_setting(1'b0, MIN_STEP, t_coord'(-32768), t_coord'(32767));
        add_random_items(60);
        settle();
        apply_setting(1'b1, T_W'($urandom_range(2048, 65535)),
                      t_coord'(int'($urandom_range(0, 4095)) - 2048),
                      t_coord'(int'($urandom_range(0, 4095)) - 2048));
        add_random_items(60);
        settle();

        send_idle_pct = 63;
        recv_idle_pct = 35;
        apply_setting(1'b0, T_W'(8000), rand_coord(), rand_coord());
        add_random_items(60);
        settle();
        apply_setting(1'b1, T_W'(1000), t_coord'(0), t_coord'(0));
        add_random_items(50);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setting(1'b0, T_STEP_RST, t_coord'(int'($urandom_range(0, 255)) - 128),
                      t_coord'(int'($urandom_range(0, 255)) - 128));
        hold_want = 1'b1;
        add_random_items(60);
        settle();
        apply_setting(1'b1, T_W'(65535), rand_coord(), rand_coord());
        add_random_items(60);
        settle();

        $display("covered %0d input items over %0d register settings", n_accepted, n_settings);
        $display("compared %0d curve points, %0d failures", n_checked, n_err);
        if (n_err == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
